[hw/rtl/tile_animation_remapper_unit_defines.svh]
// Assertion macros shared by the checker of the tile animation remapper.
// No dependencies; include by bare file name.
`ifndef TILE_ANIMATION_REMAPPER_UNIT_DEFINES_SVH
`define TILE_ANIMATION_REMAPPER_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define TAR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TAR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/tar_pkg.sv]
// Package of the tile animation remapper: field widths, codes, reset values
// and the control state type. No dependencies.
package tar_pkg;

  localparam int TILE_W  = 10;
  localparam int SLOT_W  = 6;
  localparam int FDLY_W  = 16;
  localparam int SEED_W  = 16;
  localparam int TCNT_W  = 11;
  localparam int ACNT_W  = 7;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 16;
  localparam int SPAN_W  = 11;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  localparam logic [1:0] KIND_FWD  = 2'd0;
  localparam logic [1:0] KIND_BWD  = 2'd1;
  localparam logic [1:0] KIND_RAND = 2'd2;
  localparam logic [1:0] KIND_PONG = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_RANGE  = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;
  localparam logic [1:0] STATUS_RSVD   = 2'd3;

  localparam logic [CFGI_W-1:0] CFG_TILE_COUNT  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_ANIM_COUNT  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_RANDOM_SEED = 2'd2;

  localparam logic [TCNT_W-1:0] TILE_COUNT_RST = 11'd1024;
  localparam logic [ACNT_W-1:0] ANIM_COUNT_RST = 7'd0;
  localparam logic [SEED_W-1:0] SEED_RST       = 16'd44257;
  localparam logic [SEED_W-1:0] LFSR_MASK      = 16'hB400;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_RESP,
    ST_ENT_EV,
    ST_TILE_WR,
    ST_DIV
  } state_t;

endpackage

[hw/rtl/tar_in_if.sv]
// Input channel of the tile animation remapper: valid/ready and item fields.
// Depends on tar_pkg for field widths.
interface tar_in_if
  import tar_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [SLOT_W-1:0]   anim_slot;
  logic [TILE_W-1:0]   first_tile;
  logic [TILE_W-1:0]   last_tile;
  logic [FDLY_W-1:0]   frame_delay;
  logic [1:0]          anim_kind;
  logic [TILE_W-1:0]   tile_index;

  modport source (output valid, mode, anim_slot, first_tile, last_tile, frame_delay,
                  anim_kind, tile_index, input ready);
  modport sink   (input valid, mode, anim_slot, first_tile, last_tile, frame_delay,
                  anim_kind, tile_index, output ready);
endinterface

[hw/rtl/tar_out_if.sv]
// Result channel of the tile animation remapper: valid/ready, status, tile.
// Depends on tar_pkg for field widths.
interface tar_out_if
  import tar_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [TILE_W-1:0] mapped_tile;

  modport source (output valid, status, mapped_tile, input ready);
  modport sink   (input valid, status, mapped_tile, output ready);
endinterface

[hw/rtl/tar_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held between reads. No dependencies.
module tar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[hw/rtl/tile_animation_remapper_unit.sv]
// Tile animation remapper. After reset a clearing pass over max(MAX_TILES, MAX_ANIMS)
// addresses writes the identity map and clears the animation memory; no item is taken
// then. A load or an undefined mode finishes in the idle state, a lookup after one tile
// memory read, a tick after walking the entries and their tile steps, each step a read
// ahead and a write back, plus for random mode a remainder from a one-bit-per-cycle
// divider. Items are processed one at a time; a result may wait in the output register
// while the next transaction is accepted.
module tile_animation_remapper_unit
  import tar_pkg::*;
#(
  parameter int MAX_TILES  = 1024,
  parameter int MAX_ANIMS  = 64,
  parameter int DELAY_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  tar_in_if.sink            in_chan,
  tar_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFGD_W-1:0] cfg_data
);
  localparam int TW    = $clog2(MAX_TILES);
  localparam int AW    = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
  localparam int CNW   = DELAY_BITS + 1;
  localparam int EW    = 2 * TILE_W + 2 + DELAY_BITS + CNW;
  localparam int CLR_N = (MAX_TILES > MAX_ANIMS) ? MAX_TILES : MAX_ANIMS;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [CNW-1:0] CMAX = '1;

  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] n;
    n = v >> 1;
    if (v[0]) n = n ^ LFSR_MASK;
    return n;
  endfunction

  function automatic int inc_wrap(input int v);
    return (v + 1 >= MAX_TILES) ? 0 : v + 1;
  endfunction

  function automatic int dec_wrap(input int v);
    return (v == 0) ? MAX_TILES - 1 : v - 1;
  endfunction

  // returns {bounce_down, map} for the non-random kinds
  function automatic logic [TW:0] step_map(input int m, input int f, input int l,
                                           input logic [1:0] kind, input logic bd);
    int   mn;
    logic bn;
    mn = m;
    bn = bd;
    case (kind)
      KIND_FWD: mn = (m < l) ? inc_wrap(m) : f;
      KIND_BWD: mn = (m > f) ? dec_wrap(m) : l;
      default: begin
        if (bd) begin
          if (m != f) mn = dec_wrap(m);
          else begin
            mn = inc_wrap(m);
            bn = 1'b0;
          end
        end else begin
          if (m != l) mn = inc_wrap(m);
          else begin
            mn = dec_wrap(m);
            bn = 1'b1;
          end
        end
      end
    endcase
    return {bn, TW'(mn)};
  endfunction

  state_t state_r, state_nxt;
  logic [CW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [TW-1:0]     l_r, l_nxt;
  logic [TILE_W-1:0] ef_r, ef_nxt, el_r, el_nxt;
  logic [1:0]        ek_r, ek_nxt;
  logic [SEED_W-1:0] lfsr_r, lfsr_nxt, q_r, q_nxt;
  logic [TILE_W-1:0] rem_r, rem_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;
  logic [3:0]        dcnt_r, dcnt_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [TILE_W-1:0] res_mapped_r, res_mapped_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [TILE_W-1:0] out_mapped_r, out_mapped_nxt;
  logic [TCNT_W-1:0] tile_count_r, tile_count_nxt;
  logic [ACNT_W-1:0] anim_count_r, anim_count_nxt;

  logic              tm_we, tm_re;
  logic [TW-1:0]     tm_waddr, tm_raddr;
  logic [TW:0]       tm_wdata, tm_rdata;
  logic              am_we, am_re;
  logic [AW-1:0]     am_waddr, am_raddr;
  logic [EW-1:0]     am_wdata, am_rdata;

  logic [CNW-1:0]        e_cnt;
  logic [DELAY_BITS-1:0] e_delay;
  logic [1:0]            e_kind;
  logic [TILE_W-1:0]     e_first, e_last;

  assign e_cnt   = am_rdata[CNW-1:0];
  assign e_delay = am_rdata[CNW +: DELAY_BITS];
  assign e_kind  = am_rdata[CNW+DELAY_BITS +: 2];
  assign e_last  = am_rdata[CNW+DELAY_BITS+2 +: TILE_W];
  assign e_first = am_rdata[CNW+DELAY_BITS+2+TILE_W +: TILE_W];

  tar_ram #(.WIDTH(TW + 1), .DEPTH(MAX_TILES)) u_tile_ram (
    .clk(clk), .we(tm_we), .waddr(tm_waddr), .wdata(tm_wdata),
    .re(tm_re), .raddr(tm_raddr), .rdata(tm_rdata)
  );

  tar_ram #(.WIDTH(EW), .DEPTH(MAX_ANIMS)) u_anim_ram (
    .clk(clk), .we(am_we), .waddr(am_waddr), .wdata(am_wdata),
    .re(am_re), .raddr(am_raddr), .rdata(am_rdata)
  );

  always_comb begin
    logic              out_free, fin, adv_tile, adv_entry, fire, bad;
    logic [1:0]        fin_status;
    logic [TILE_W-1:0] fin_mapped;
    logic [CNW-1:0]    cnt_new;
    logic [SPAN_W-1:0] t;
    logic [TW:0]       stp;
    int                n_eff;

    out_free   = !out_valid_r || out_chan.ready;
    n_eff      = (32'(anim_count_r) < MAX_ANIMS) ? 32'(anim_count_r) : MAX_ANIMS;
    fin        = 1'b0;
    fin_status = STATUS_OK;
    fin_mapped = '0;
    adv_tile   = 1'b0;
    adv_entry  = 1'b0;
    fire       = 1'b0;
    bad        = 1'b0;
    cnt_new    = '0;
    t          = '0;
    stp        = '0;

    state_nxt      = state_r;
    clr_nxt        = clr_r;
    k_nxt          = k_r;
    l_nxt          = l_r;
    ef_nxt         = ef_r;
    el_nxt         = el_r;
    ek_nxt         = ek_r;
    lfsr_nxt       = lfsr_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    span_nxt       = span_r;
    dcnt_nxt       = dcnt_r;
    res_status_nxt = res_status_r;
    res_mapped_nxt = res_mapped_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_mapped_nxt = out_mapped_r;
    tile_count_nxt = tile_count_r;
    anim_count_nxt = anim_count_r;

    in_chan.ready = 1'b0;
    tm_we    = 1'b0;
    tm_waddr = l_r;
    tm_wdata = '0;
    tm_re    = 1'b0;
    tm_raddr = l_r;
    am_we    = 1'b0;
    am_waddr = k_r;
    am_wdata = '0;
    am_re    = 1'b0;
    am_raddr = k_r;

    unique case (state_r)
      ST_CLEAR: begin
        if (32'(clr_r) < MAX_TILES) begin
          tm_we    = 1'b1;
          tm_waddr = TW'(clr_r);
          tm_wdata = {1'b0, TW'(clr_r)};
        end
        if (32'(clr_r) < MAX_ANIMS) begin
          am_we    = 1'b1;
          am_waddr = AW'(clr_r);
        end
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == CLR_N - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          case (in_chan.mode)
            MODE_LOAD: begin
              bad = 32'(in_chan.anim_slot) >= MAX_ANIMS
                 || 32'(in_chan.first_tile) >= 32'(tile_count_r)
                 || 32'(in_chan.first_tile) >= MAX_TILES
                 || 32'(in_chan.last_tile) >= 32'(tile_count_r)
                 || 32'(in_chan.last_tile) >= MAX_TILES;
              if (!bad) begin
                am_we    = 1'b1;
                am_waddr = AW'(in_chan.anim_slot);
                am_wdata = {in_chan.first_tile, in_chan.last_tile, in_chan.anim_kind,
                            DELAY_BITS'(in_chan.frame_delay), CNW'(0)};
              end
              fin        = 1'b1;
              fin_status = bad ? STATUS_REJECT : STATUS_OK;
            end
            MODE_TICK: begin
              if (n_eff == 0) begin
                fin = 1'b1;
              end else begin
                k_nxt     = '0;
                am_re     = 1'b1;
                am_raddr  = '0;
                state_nxt = ST_ENT_EV;
              end
            end
            MODE_LOOKUP: begin
              if (32'(in_chan.tile_index) >= 32'(tile_count_r)
                  || 32'(in_chan.tile_index) >= MAX_TILES) begin
                fin        = 1'b1;
                fin_status = STATUS_RANGE;
              end else begin
                tm_re     = 1'b1;
                tm_raddr  = TW'(in_chan.tile_index);
                state_nxt = ST_LOOK;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_LOOK: begin
        fin = 1'b1;
        if (32'(tm_rdata[TW-1:0]) >= 32'(tile_count_r)) begin
          fin_status = STATUS_RANGE;
        end else begin
          fin_mapped = TILE_W'(tm_rdata[TW-1:0]);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_mapped_nxt = res_mapped_r;
          state_nxt      = ST_IDLE;
        end
      end
      ST_ENT_EV: begin
        fire    = (e_delay != '0) && (CNW'(e_delay) < e_cnt);
        // a firing entry clears to zero and then counts this tick
        cnt_new = fire ? CNW'(1) : ((e_cnt == CMAX) ? e_cnt : e_cnt + 1'b1);
        am_we    = 1'b1;
        am_waddr = k_r;
        am_wdata = {e_first, e_last, e_kind, e_delay, cnt_new};
        ef_nxt   = e_first;
        el_nxt   = e_last;
        ek_nxt   = e_kind;
        if (fire && e_first <= e_last && 32'(e_last) < MAX_TILES) begin
          l_nxt     = TW'(e_first);
          tm_re     = 1'b1;
          tm_raddr  = TW'(e_first);
          state_nxt = ST_TILE_WR;
        end else begin
          adv_entry = 1'b1;
        end
      end
      ST_TILE_WR: begin
        if (ek_r == KIND_RAND) begin
          lfsr_nxt  = lfsr_step(lfsr_r);
          q_nxt     = lfsr_step(lfsr_r);
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          span_nxt  = SPAN_W'(el_r) - SPAN_W'(ef_r) + 1'b1;
          state_nxt = ST_DIV;
        end else begin
          stp      = step_map(32'(tm_rdata[TW-1:0]), 32'(ef_r), 32'(el_r), ek_r,
                              tm_rdata[TW]);
          tm_we    = 1'b1;
          tm_waddr = l_r;
          tm_wdata = stp;
          adv_tile = 1'b1;
        end
      end
      ST_DIV: begin
        // restoring remainder, one dividend bit per cycle, msb first
        t = {rem_r, q_r[SEED_W-1]};
        if (t >= span_r) t = t - span_r;
        rem_nxt  = TILE_W'(t);
        q_nxt    = q_r << 1;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 4'd15) begin
          tm_we    = 1'b1;
          tm_waddr = l_r;
          tm_wdata = {tm_rdata[TW], TW'(32'(ef_r) + 32'(t))};
          adv_tile = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (adv_tile) begin
      if (32'(l_r) == 32'(el_r)) begin
        adv_entry = 1'b1;
      end else begin
        l_nxt     = l_r + 1'b1;
        tm_re     = 1'b1;
        tm_raddr  = l_r + 1'b1;
        state_nxt = ST_TILE_WR;
      end
    end

    if (adv_entry) begin
      if (32'(k_r) + 1 >= n_eff) begin
        fin = 1'b1;
      end else begin
        k_nxt     = k_r + 1'b1;
        am_re     = 1'b1;
        am_raddr  = k_r + 1'b1;
        state_nxt = ST_ENT_EV;
      end
    end

    if (fin) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fin_status;
        out_mapped_nxt = fin_mapped;
        state_nxt      = ST_IDLE;
      end else begin
        res_status_nxt = fin_status;
        res_mapped_nxt = fin_mapped;
        state_nxt      = ST_RESP;
      end
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_TILE_COUNT:  tile_count_nxt = TCNT_W'(cfg_data);
        CFG_ANIM_COUNT:  anim_count_nxt = ACNT_W'(cfg_data);
        CFG_RANDOM_SEED: lfsr_nxt = (cfg_data == '0) ? SEED_W'(1) : SEED_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      tile_count_r <= TILE_COUNT_RST;
      anim_count_r <= ANIM_COUNT_RST;
      lfsr_r       <= SEED_RST;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      tile_count_r <= tile_count_nxt;
      anim_count_r <= anim_count_nxt;
      lfsr_r       <= lfsr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    l_r          <= l_nxt;
    ef_r         <= ef_nxt;
    el_r         <= el_nxt;
    ek_r         <= ek_nxt;
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    span_r       <= span_nxt;
    dcnt_r       <= dcnt_nxt;
    res_status_r <= res_status_nxt;
    res_mapped_r <= res_mapped_nxt;
    out_status_r <= out_status_nxt;
    out_mapped_r <= out_mapped_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.mapped_tile = out_mapped_r;
endmodule

[hw/rtl/tar_checker.sv]
// Port-level checker of the tile animation remapper, bound to the top level.
// Depends on tar_pkg and tile_animation_remapper_unit_defines.svh.
`include "tile_animation_remapper_unit_defines.svh"

module tar_checker
  import tar_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic [TILE_W-1:0] out_mapped
);
  // transactions accepted but not yet delivered
  logic [1:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) pend_nxt = pend_r + 1'b1;
    if (!(in_valid && in_ready) && (out_valid && out_ready)) pend_nxt = pend_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `TAR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `TAR_ASSERT(a_pend_bound, clk, rst_n, pend_r != 2'd3, "more than two transactions in flight")
  `TAR_ASSERT(a_no_orphan, clk, rst_n, out_valid |-> pend_r != 2'd0, "result without accepted item")
  `TAR_ASSERT(a_err_zero, clk, rst_n, out_valid && out_status != STATUS_OK |-> out_mapped == '0, "error result carries a tile")
  `TAR_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid && out_status != STATUS_RSVD || !out_valid, "result right after reset")
endmodule

bind tile_animation_remapper_unit tar_checker u_tar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_mapped (out_chan.mapped_tile)
);

[tb/tb.sv]
// Self-checking bench for tile_animation_remapper_unit: directed then random
// load/tick/lookup transactions, checked against an in-bench remap table model.
// Depends on tar_pkg, tar_in_if, tar_out_if and the RTL top level.
module tb;
  import tar_pkg::*;

  localparam int NTILES   = 1024;
  localparam int NANIMS   = 64;
  localparam int WATCHDOG = 300000;

  typedef struct {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot;
    logic [TILE_W-1:0] first;
    logic [TILE_W-1:0] last;
    logic [FDLY_W-1:0] delay;
    logic [1:0]        kind;
    logic [TILE_W-1:0] idx;
  } remap_req_t;

  typedef struct {
    logic [1:0]        status;
    logic [TILE_W-1:0] mapped;
  } remap_resp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFGD_W-1:0] cfg_data;

  tar_in_if  in_if ();
  tar_out_if out_if ();

  tile_animation_remapper_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // remap table model
  logic [TILE_W-1:0] map_tbl [NTILES];
  bit                bounce_dn [NTILES];
  logic [TILE_W-1:0] ent_first [NANIMS];
  logic [TILE_W-1:0] ent_last [NANIMS];
  logic [FDLY_W-1:0] ent_delay [NANIMS];
  logic [1:0]        ent_kind [NANIMS];
  logic [16:0]       frame_cnt [NANIMS];
  logic [15:0]       lfsr_val;
  logic [TCNT_W-1:0] tile_count_r;
  logic [ACNT_W-1:0] anim_count_r;
  bit                slot_loaded [NANIMS];

  remap_req_t  pending_reqs[$];
  remap_resp_t expected_resps[$];
  int errors;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int tiles_eff();
    return (tile_count_r < NTILES) ? int'(tile_count_r) : NTILES;
  endfunction

  function automatic int inc_wrap(int v);
    return (v + 1 >= NTILES) ? 0 : v + 1;
  endfunction

  function automatic int dec_wrap(int v);
    return (v == 0) ? NTILES - 1 : v - 1;
  endfunction

  function automatic void step_tile(int k, int l);
    int m;
    int f;
    int la;
    logic lsb;
    m  = map_tbl[l];
    f  = ent_first[k];
    la = ent_last[k];
    case (ent_kind[k])
      KIND_FWD: m = (m < la) ? inc_wrap(m) : f;
      KIND_BWD: m = (m > f) ? dec_wrap(m) : la;
      KIND_RAND: begin
        lsb = lfsr_val[0];
        lfsr_val = lfsr_val >> 1;
        if (lsb) lfsr_val = lfsr_val ^ LFSR_MASK;
        m = f + int'(lfsr_val) % (la - f + 1);
      end
      default: begin
        if (bounce_dn[l]) begin
          if (m != f) m = dec_wrap(m);
          else begin
            m = inc_wrap(m);
            bounce_dn[l] = 1'b0;
          end
        end else begin
          if (m != la) m = inc_wrap(m);
          else begin
            m = dec_wrap(m);
            bounce_dn[l] = 1'b1;
          end
        end
      end
    endcase
    map_tbl[l] = m[TILE_W-1:0];
  endfunction

  function automatic void advance_frames();
    int n;
    n = (anim_count_r < NANIMS) ? int'(anim_count_r) : NANIMS;
    for (int k = 0; k < n; k++) begin
      if (ent_delay[k] != 0 && {1'b0, ent_delay[k]} < frame_cnt[k]) begin
        frame_cnt[k] = '0;
        if (ent_first[k] <= ent_last[k])
          for (int l = ent_first[k]; l <= ent_last[k]; l++) step_tile(k, l);
      end
      if (frame_cnt[k] != 17'h1FFFF) frame_cnt[k] = frame_cnt[k] + 17'd1;
    end
  endfunction

  function automatic void remap_predict(remap_req_t it);
    remap_resp_t r;
    int nt;
    nt = tiles_eff();
    r.status = STATUS_OK;
    r.mapped = '0;
    case (it.mode)
      MODE_LOAD: begin
        if (it.first >= nt || it.last >= nt) r.status = STATUS_REJECT;
        else begin
          ent_first[it.slot] = it.first;
          ent_last[it.slot]  = it.last;
          ent_delay[it.slot] = it.delay;
          ent_kind[it.slot]  = it.kind;
          frame_cnt[it.slot] = '0;
        end
      end
      MODE_TICK: advance_frames();
      MODE_LOOKUP: begin
        if (it.idx >= nt || map_tbl[it.idx] >= nt) r.status = STATUS_RANGE;
        else r.mapped = map_tbl[it.idx];
      end
      default: ;
    endcase
    expected_resps.push_back(r);
  endfunction

  // generation side: longest run of loaded slots from zero bounds anim_count
  function automatic int loaded_prefix();
    int p;
    p = 0;
    while (p < NANIMS && slot_loaded[p]) p++;
    return p;
  endfunction

  task automatic push_load(int slot, int f, int l, int d, logic [1:0] k);
    remap_req_t it;
    it.mode  = MODE_LOAD;
    it.slot  = slot[SLOT_W-1:0];
    it.first = f[TILE_W-1:0];
    it.last  = l[TILE_W-1:0];
    it.delay = d[FDLY_W-1:0];
    it.kind  = k;
    it.idx   = TILE_W'($urandom);
    if (f < tiles_eff() && l < tiles_eff()) slot_loaded[slot] = 1'b1;
    pending_reqs.push_back(it);
  endtask

  task automatic push_other(logic [1:0] mode, int idx);
    remap_req_t it;
    it.mode  = mode;
    it.slot  = SLOT_W'($urandom);
    it.first = TILE_W'($urandom);
    it.last  = TILE_W'($urandom);
    it.delay = FDLY_W'($urandom);
    it.kind  = 2'($urandom);
    it.idx   = idx[TILE_W-1:0];
    pending_reqs.push_back(it);
  endtask

  task automatic push_random();
    int r;
    int nt;
    int pre;
    int slot;
    int f;
    int l;
    int d;
    int sel;
    logic [1:0] k;
    r  = $urandom_range(0, 99);
    nt = tiles_eff();
    if (r < 45) begin
      push_other(MODE_LOOKUP, $urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, nt - 1));
    end else if (r < 56) begin
      push_other(MODE_TICK, $urandom);
    end else if (r < 93) begin
      pre  = loaded_prefix();
      slot = ($urandom_range(0, 3) != 0) ? $urandom_range(0, (pre < 63) ? pre : 63)
                                         : $urandom_range(0, 63);
      k    = 2'($urandom);
      f    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, nt - 1);
      sel  = $urandom_range(0, 99);
      if (k == KIND_RAND) l = f + $urandom_range(0, 7);
      else if (sel < 90) l = f + $urandom_range(0, 15);
      else if (sel < 94) l = f + $urandom_range(0, 1023);
      else l = f - $urandom_range(1, 8);
      if (l > 1023) l = 1023;
      if (l < 0) l = 0;
      sel = $urandom_range(0, 9);
      d   = (sel < 8) ? $urandom_range(1, 6) : (sel == 8) ? $urandom_range(0, 65535) : 0;
      push_load(slot, f, l, d, k);
    end else begin
      push_other(MODE_RSVD, $urandom);
    end
  endtask

  task automatic cfg_write(logic [CFGI_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFGD_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TILE_COUNT:  tile_count_r = val[TCNT_W-1:0];
      CFG_ANIM_COUNT:  anim_count_r = val[ACNT_W-1:0];
      CFG_RANDOM_SEED: lfsr_val = (val[15:0] == 0) ? 16'd1 : val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || in_if.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver: bursts of transactions with random gaps
  remap_req_t held;
  bit in_busy;
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_busy = 0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        remap_predict(held);
        in_busy = 0;
      end
      if (!in_busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          held = pending_reqs.pop_front();
          in_if.valid       <= 1'b1;
          in_if.mode        <= held.mode;
          in_if.anim_slot   <= held.slot;
          in_if.first_tile  <= held.first;
          in_if.last_tile   <= held.last;
          in_if.frame_delay <= held.delay;
          in_if.anim_kind   <= held.kind;
          in_if.tile_index  <= held.idx;
          in_busy = 1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stall pattern, result check, watchdog
  int cyc;
  int stall_kind;
  int quiet;
  remap_resp_t exp_r;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      cyc = 0;
      stall_kind = 0;
      quiet = 0;
    end else begin
      cyc++;
      if (cyc % 64 == 0) stall_kind = $urandom_range(0, 2);
      case (stall_kind)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        default: out_if.ready <= (cyc % 3 != 0);
      endcase
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (out_if.valid && out_if.ready) begin
        if (expected_resps.size() == 0) begin
          $error("unexpected result: status %0d mapped_tile %0d",
                 out_if.status, out_if.mapped_tile);
          errors++;
        end else begin
          exp_r = expected_resps.pop_front();
          if (out_if.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_if.status);
            errors++;
          end
          if (out_if.mapped_tile !== exp_r.mapped) begin
            $error("mapped_tile: expected %0d, actual %0d", exp_r.mapped, out_if.mapped_tile);
            errors++;
          end
        end
      end
      if (quiet >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int pre;
    errors = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.mode = '0;
    in_if.anim_slot = '0;
    in_if.first_tile = '0;
    in_if.last_tile = '0;
    in_if.frame_delay = '0;
    in_if.anim_kind = '0;
    in_if.tile_index = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < NTILES; i++) begin
      map_tbl[i] = TILE_W'(i);
      bounce_dn[i] = 1'b0;
    end
    for (int k = 0; k < NANIMS; k++) begin
      frame_cnt[k] = '0;
      slot_loaded[k] = 1'b0;
    end
    tile_count_r = TILE_COUNT_RST;
    anim_count_r = ANIM_COUNT_RST;
    lfsr_val = SEED_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // one entry of each kind, reversed range, disabled entry, full-range slot
    push_load(0, 2, 5, 1, KIND_FWD);
    push_load(1, 10, 13, 2, KIND_BWD);
    push_load(2, 20, 27, 1, KIND_RAND);
    push_load(3, 30, 33, 1, KIND_PONG);
    push_load(4, 40, 35, 1, KIND_FWD);
    push_load(5, 50, 52, 0, KIND_FWD);
    push_load(63, 0, 1023, 65535, KIND_PONG);
    push_other(MODE_LOOKUP, 0);
    push_other(MODE_LOOKUP, 1023);
    push_other(MODE_RSVD, 0);
    drain();
    cfg_write(CFG_ANIM_COUNT, 6);
    cfg_write(CFG_RANDOM_SEED, 1);
    repeat (7) push_other(MODE_TICK, 0);
    for (int i = 2; i < 6; i++) push_other(MODE_LOOKUP, i);
    push_other(MODE_LOOKUP, 21);
    push_other(MODE_LOOKUP, 31);
    drain();
    // small tile count: rejected load, out-of-range index and map
    cfg_write(CFG_TILE_COUNT, 3);
    push_load(8, 5, 5, 1, KIND_FWD);
    push_other(MODE_LOOKUP, 2);
    push_other(MODE_LOOKUP, 3);
    push_other(MODE_LOOKUP, 0);
    drain();

    for (int p = 0; p < 12; p++) begin
      case (p % 6)
        0: cfg_write(CFG_TILE_COUNT, 1024);
        1: cfg_write(CFG_TILE_COUNT, $urandom_range(1, 1024));
        2: cfg_write(CFG_TILE_COUNT, 2047);
        3: cfg_write(CFG_TILE_COUNT, 1);
        4: cfg_write(CFG_TILE_COUNT, $urandom_range(16, 200));
        default: cfg_write(CFG_TILE_COUNT, 1024);
      endcase
      case (p % 4)
        0: cfg_write(CFG_RANDOM_SEED, $urandom_range(1, 65535));
        1: cfg_write(CFG_RANDOM_SEED, 65535);
        2: cfg_write(CFG_RANDOM_SEED, 0);
        default: cfg_write(CFG_RANDOM_SEED, 1);
      endcase
      pre = loaded_prefix();
      if (pre == NANIMS) begin
        case ($urandom_range(0, 2))
          0: cfg_write(CFG_ANIM_COUNT, 64);
          1: cfg_write(CFG_ANIM_COUNT, 127);
          default: cfg_write(CFG_ANIM_COUNT, $urandom_range(0, 64));
        endcase
      end else begin
        cfg_write(CFG_ANIM_COUNT, $urandom_range(0, pre));
      end
      repeat (92) push_random();
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
